// File: rtl/prm_pkg.sv
// ----------------------------------------------------------------------------
// prm_pkg: shared types and constants of the peak region merger
// Field widths, register indexes, tie store entry and close descriptors.
// ----------------------------------------------------------------------------
`default_nettype none

package prm_pkg;

    localparam int POS_W   = 30;
    localparam int TREAT_W = 16;
    localparam int CTL_W   = 24;
    localparam int Q_W     = 16;
    localparam int GAP_W   = 16;

    localparam int S_TDATA_W = 88;
    localparam int M_TDATA_W = 152;
    localparam int CFG_IDX_W = 2;

    typedef logic [POS_W-1:0]   pos_t;
    typedef logic [TREAT_W-1:0] treat_t;
    typedef logic [CTL_W-1:0]   ctl_t;
    typedef logic [Q_W-1:0]     qscore_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_Q_CUTOFF   = 2'd0,
        CFG_MAX_GAP    = 2'd1,
        CFG_MIN_LENGTH = 2'd2
    } cfg_reg_t;

    // one tie store entry: summit candidate of a bin
    typedef struct packed {
        pos_t    mid;
        ctl_t    ctl;
        qscore_t q;
    } tie_entry_t;

    // a peak that is being closed, before its summit is read back
    typedef struct packed {
        logic   valid;
        logic   len_ok;
        pos_t   peak_begin;
        pos_t   peak_span;
        treat_t best_treat;
        logic   ovf;
    } close_desc_t;

    typedef struct packed {
        logic    last_of_run;
        logic    ties_overflowed;
        qscore_t summit_q;
        ctl_t    apex_ctl;
        treat_t  apex_treat;
        pos_t    summit_pos;
        pos_t    peak_span;
        pos_t    peak_begin;
    } peak_result_t;

    function automatic pos_t span_of(input pos_t first, input pos_t last);
        span_of = (last >= first) ? (last - first) : '0;
    endfunction

    // summit treatment must reach the control level (1/256 units)
    function automatic logic treat_ok(input treat_t treat, input ctl_t ctl);
        treat_ok = ({treat, 8'h00} >= ctl);
    endfunction

endpackage

`default_nettype wire

// File: rtl/prm_tie_ram.sv
// ----------------------------------------------------------------------------
// prm_tie_ram: tie store memory
// One write port, two registered read ports that return the old data on a
// same-cycle write.
// ----------------------------------------------------------------------------
`default_nettype none

module prm_tie_ram #(
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                aclk,
    input  wire logic                wr_en,
    input  wire logic [AW-1:0]       wr_addr,
    input  wire prm_pkg::tie_entry_t wr_data,
    input  wire logic                rd_en,
    input  wire logic [AW-1:0]       rd_addr_a,
    input  wire logic [AW-1:0]       rd_addr_b,
    output prm_pkg::tie_entry_t      rd_data_a,
    output prm_pkg::tie_entry_t      rd_data_b
);

    prm_pkg::tie_entry_t mem [DEPTH];
    prm_pkg::tie_entry_t rd_data_a_reg;
    prm_pkg::tie_entry_t rd_data_b_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_a_reg <= mem[rd_addr_a];
            rd_data_b_reg <= mem[rd_addr_b];
        end
    end

    assign rd_data_a = rd_data_a_reg;
    assign rd_data_b = rd_data_b_reg;

endmodule

`default_nettype wire

// File: rtl/prm_tracker.sv
// ----------------------------------------------------------------------------
// prm_tracker: open peak state and bin merge decisions
// Joins or splits bins, keeps the best treatment and tie count, issues tie
// store writes and the summit reads of the peaks closed by an item.
// ----------------------------------------------------------------------------
`default_nettype none

module prm_tracker #(
    parameter int MAX_TIES = 64,
    localparam int IDX_W = (MAX_TIES > 1) ? $clog2(MAX_TIES) : 1,
    localparam int CNT_W = $clog2(MAX_TIES + 1)
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   accept,
    input  wire prm_pkg::pos_t          bin_end,
    input  wire prm_pkg::treat_t        treat_pileup,
    input  wire prm_pkg::ctl_t          control_level,
    input  wire prm_pkg::qscore_t       bin_q_score,
    input  wire logic                   chrom_last,
    input  wire logic [prm_pkg::Q_W-1:0]   q_cutoff,
    input  wire logic [prm_pkg::GAP_W-1:0] max_gap,
    input  wire prm_pkg::pos_t          min_length,
    output prm_pkg::close_desc_t        close_a,
    output prm_pkg::close_desc_t        close_b,
    output logic                        wr_en,
    output logic [IDX_W-1:0]            wr_addr,
    output prm_pkg::tie_entry_t         wr_entry,
    output logic [IDX_W-1:0]            rd_addr_a,
    output logic [IDX_W-1:0]            rd_addr_b,
    output logic                        byp_b
);

    prm_pkg::pos_t   prev_end_reg,   prev_end_next;
    logic            open_reg,       open_next;
    prm_pkg::pos_t   open_start_reg, open_start_next;
    prm_pkg::pos_t   last_end_reg,   last_end_next;
    prm_pkg::treat_t best_reg,       best_next;
    logic [CNT_W-1:0] cnt_reg,       cnt_next;
    logic            ovf_reg,        ovf_next;

    logic [prm_pkg::POS_W:0] mid_sum;
    logic [prm_pkg::POS_W:0] reach;
    logic            qual;
    logic            join_peak;
    logic            start_new;
    logic            still_open;
    prm_pkg::treat_t base_best;
    logic [CNT_W-1:0] base_cnt;
    logic            base_ovf;

    // lower-middle tie: (count + 1) / 2 - 1
    function automatic logic [IDX_W-1:0] mid_index(input logic [CNT_W-1:0] cnt);
        logic [CNT_W:0] half;
        logic [CNT_W:0] idx;
        half = ({1'b0, cnt} + (CNT_W+1)'(1)) >> 1;
        idx  = half - (CNT_W+1)'(1);
        mid_index = idx[IDX_W-1:0];
    endfunction

    always_comb begin
        mid_sum   = {1'b0, prev_end_reg} + {1'b0, bin_end};
        reach     = {1'b0, last_end_reg} + (prm_pkg::POS_W+1)'(max_gap);
        qual      = (bin_q_score > q_cutoff);
        join_peak = qual && open_reg && ({1'b0, prev_end_reg} <= reach);
        start_new = qual && !join_peak;

        base_best = start_new ? '0 : best_reg;
        base_cnt  = start_new ? '0 : cnt_reg;
        base_ovf  = start_new ? 1'b0 : ovf_reg;

        open_start_next = start_new ? prev_end_reg : open_start_reg;
        last_end_next   = qual ? bin_end : last_end_reg;
        still_open      = open_reg || qual;

        best_next = best_reg;
        cnt_next  = cnt_reg;
        ovf_next  = ovf_reg;
        wr_en     = 1'b0;
        wr_addr   = '0;
        wr_entry  = '{mid: mid_sum[prm_pkg::POS_W:1], ctl: control_level, q: bin_q_score};

        if (qual) begin
            best_next = base_best;
            cnt_next  = base_cnt;
            ovf_next  = base_ovf;
            // a zero best restarts the list on every bin
            if (base_best == '0 || treat_pileup > base_best) begin
                best_next = treat_pileup;
                cnt_next  = CNT_W'(1);
                ovf_next  = 1'b0;
                wr_en     = 1'b1;
            end else if (treat_pileup == base_best) begin
                if (base_cnt < CNT_W'(MAX_TIES)) begin
                    wr_en    = 1'b1;
                    wr_addr  = base_cnt[IDX_W-1:0];
                    cnt_next = base_cnt + CNT_W'(1);
                end else begin
                    ovf_next = 1'b1;
                end
            end
        end

        prev_end_next = chrom_last ? '0 : bin_end;
        open_next     = chrom_last ? 1'b0 : still_open;

        // peak closed by a gap, taken from the state before this item
        close_a.valid      = qual && open_reg && !join_peak;
        close_a.peak_begin = open_start_reg;
        close_a.peak_span  = prm_pkg::span_of(open_start_reg, last_end_reg);
        close_a.len_ok     = (close_a.peak_span >= min_length);
        close_a.best_treat = best_reg;
        close_a.ovf        = ovf_reg;
        rd_addr_a          = mid_index(cnt_reg);

        // peak closed at the chromosome end, after this item
        close_b.valid      = chrom_last && still_open;
        close_b.peak_begin = open_start_next;
        close_b.peak_span  = prm_pkg::span_of(open_start_next, last_end_next);
        close_b.len_ok     = (close_b.peak_span >= min_length);
        close_b.best_treat = best_next;
        close_b.ovf        = ovf_next;
        rd_addr_b          = mid_index(cnt_next);

        // summit entry written in the same cycle: forward it
        byp_b = wr_en && (wr_addr == rd_addr_b);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_end_reg <= '0;
            open_reg     <= 1'b0;
            cnt_reg      <= '0;
            ovf_reg      <= 1'b0;
            best_reg     <= '0;
        end else if (accept) begin
            prev_end_reg <= prev_end_next;
            open_reg     <= open_next;
            cnt_reg      <= cnt_next;
            ovf_reg      <= ovf_next;
            best_reg     <= best_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            open_start_reg <= open_start_next;
            last_end_reg   <= last_end_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/prm_emitter.sv
// ----------------------------------------------------------------------------
// prm_emitter: summit check and result output
// Holds the peaks closed by the last item until their summits are checked
// and hands the reported ones to the output register one at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module prm_emitter (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    output logic                       accept,
    input  wire prm_pkg::close_desc_t  close_a,
    input  wire prm_pkg::close_desc_t  close_b,
    input  wire prm_pkg::tie_entry_t   rd_data_a,
    input  wire prm_pkg::tie_entry_t   rd_data_b,
    input  wire logic                  byp_b,
    input  wire prm_pkg::tie_entry_t   byp_entry,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output prm_pkg::peak_result_t      out_result
);

    logic                  a_valid_reg;
    logic                  b_valid_reg;
    prm_pkg::close_desc_t  a_desc_reg;
    prm_pkg::close_desc_t  b_desc_reg;
    logic                  byp_reg;
    prm_pkg::tie_entry_t   byp_entry_reg;
    logic                  out_valid_reg;
    prm_pkg::peak_result_t out_result_reg;

    prm_pkg::tie_entry_t   entry_b;
    logic                  pend_a;
    logic                  pend_b;
    logic                  out_free;

    function automatic prm_pkg::peak_result_t make_result(
        input prm_pkg::close_desc_t d,
        input prm_pkg::tie_entry_t  e,
        input logic                 last
    );
        prm_pkg::peak_result_t r;
        r.peak_begin      = d.peak_begin;
        r.peak_span       = d.peak_span;
        r.summit_pos      = e.mid;
        r.apex_treat      = d.best_treat;
        r.apex_ctl        = e.ctl;
        r.summit_q        = e.q;
        r.ties_overflowed = d.ovf;
        r.last_of_run     = last;
        make_result = r;
    endfunction

    always_comb begin
        entry_b  = byp_reg ? byp_entry_reg : rd_data_b;
        pend_a   = a_valid_reg && a_desc_reg.len_ok
                   && prm_pkg::treat_ok(a_desc_reg.best_treat, rd_data_a.ctl);
        pend_b   = b_valid_reg && b_desc_reg.len_ok
                   && prm_pkg::treat_ok(b_desc_reg.best_treat, entry_b.ctl);
        out_free = !out_valid_reg || out_ready;
        // ready if no reported peak waits, or output free and only one waits
        in_ready = (!pend_a && !pend_b) || (out_free && !(pend_a && pend_b));
        accept   = in_valid && in_ready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                a_valid_reg <= close_a.valid;
                b_valid_reg <= close_b.valid;
            end else if (out_free) begin
                if (pend_a) begin
                    a_valid_reg <= 1'b0;
                end else if (pend_b) begin
                    b_valid_reg <= 1'b0;
                end
            end
            if (out_free) begin
                out_valid_reg <= pend_a || pend_b;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            a_desc_reg    <= close_a;
            b_desc_reg    <= close_b;
            byp_reg       <= byp_b;
            byp_entry_reg <= byp_entry;
        end
        if (out_free && (pend_a || pend_b)) begin
            out_result_reg <= pend_a ? make_result(a_desc_reg, rd_data_a, !pend_b)
                                     : make_result(b_desc_reg, entry_b, 1'b1);
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_result = out_result_reg;

endmodule

`default_nettype wire

// File: rtl/peak_region_merger.sv
// ----------------------------------------------------------------------------
// peak_region_merger: merges above-cutoff pileup bins into reported peaks
// Top level: configuration registers, tie store and the two pipeline parts.
// ----------------------------------------------------------------------------
// Usage
//   s_ channel: one pileup bin per item, in position order; s_tlast marks the
//   last bin of a chromosome and closes the open peak.
//   m_ channel: one reported peak per item; m_tlast marks the final peak that
//   a given input bin produced, m_tuser flags dropped summit ties.
//   cfg channel: register writes (q_cutoff, max_gap, min_length), always
//   ready; write only while no bin is in flight.
//   Output path: the closing descriptors and summit reads are registered
//   when the bin is accepted, then a reported peak moves into the output
//   register that drives m_tvalid; a second peak of that bin follows it.
//   Throughput: one bin per cycle while s_tready is high. A bin that closes
//   two reported peaks holds s_tready low until one has moved on, since the
//   output register moves at most one peak per cycle. Summits come from the
//   tie store's registered read ports; port b forwards a same-cycle write.
//   Stall: while m_tready is low the held result stays on m_ and s_tready
//   drops as soon as a further reported peak is waiting.
//   Reset: clears peak state, pending results and loads register defaults;
//   the tie store needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module peak_region_merger #(
    parameter int MAX_TIES = 64
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // bin_end, treat_pileup, control_level, bin_q_score (lowest bits first)
    input  wire logic [prm_pkg::S_TDATA_W-1:0]     s_tdata,
    input  wire logic                              s_tlast,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // peak_begin, peak_span, summit_pos, apex_treat, apex_ctl, summit_q
    output logic [prm_pkg::M_TDATA_W-1:0]          m_tdata,
    // ties_overflowed
    output logic                                   m_tuser,
    output logic                                   m_tlast,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [prm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [prm_pkg::POS_W-1:0]         cfg_data
);

    localparam int IDX_W = (MAX_TIES > 1) ? $clog2(MAX_TIES) : 1;

    logic [prm_pkg::Q_W-1:0]   q_cutoff_reg;
    logic [prm_pkg::GAP_W-1:0] max_gap_reg;
    prm_pkg::pos_t             min_length_reg;

    prm_pkg::close_desc_t  close_a;
    prm_pkg::close_desc_t  close_b;
    logic                  accept;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    prm_pkg::tie_entry_t   wr_entry;
    logic [IDX_W-1:0]      rd_addr_a;
    logic [IDX_W-1:0]      rd_addr_b;
    logic                  byp_b;
    prm_pkg::tie_entry_t   rd_data_a;
    prm_pkg::tie_entry_t   rd_data_b;
    prm_pkg::peak_result_t result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_cutoff_reg   <= 16'd512;
            max_gap_reg    <= 16'd50;
            min_length_reg <= 30'd200;
        end else if (cfg_valid) begin
            case (cfg_index)
                prm_pkg::CFG_Q_CUTOFF: begin
                    q_cutoff_reg <= cfg_data[prm_pkg::Q_W-1:0];
                end
                prm_pkg::CFG_MAX_GAP: begin
                    max_gap_reg <= cfg_data[prm_pkg::GAP_W-1:0];
                end
                prm_pkg::CFG_MIN_LENGTH: begin
                    min_length_reg <= cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    prm_tracker #(
        .MAX_TIES(MAX_TIES)
    ) u_tracker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .accept        (accept),
        .bin_end       (s_tdata[29:0]),
        .treat_pileup  (s_tdata[45:30]),
        .control_level (s_tdata[69:46]),
        .bin_q_score   (s_tdata[85:70]),
        .chrom_last    (s_tlast),
        .q_cutoff      (q_cutoff_reg),
        .max_gap       (max_gap_reg),
        .min_length    (min_length_reg),
        .close_a       (close_a),
        .close_b       (close_b),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_entry      (wr_entry),
        .rd_addr_a     (rd_addr_a),
        .rd_addr_b     (rd_addr_b),
        .byp_b         (byp_b)
    );

    prm_tie_ram #(
        .DEPTH(MAX_TIES)
    ) u_tie_ram (
        .aclk      (aclk),
        .wr_en     (wr_en && accept),
        .wr_addr   (wr_addr),
        .wr_data   (wr_entry),
        .rd_en     (accept),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    prm_emitter u_emitter (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .accept     (accept),
        .close_a    (close_a),
        .close_b    (close_b),
        .rd_data_a  (rd_data_a),
        .rd_data_b  (rd_data_b),
        .byp_b      (byp_b),
        .byp_entry  (wr_entry),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result)
    );

    assign m_tdata = {6'b0, result.summit_q, result.apex_ctl, result.apex_treat,
                      result.summit_pos, result.peak_span, result.peak_begin};
    assign m_tuser = result.ties_overflowed;
    assign m_tlast = result.last_of_run;

endmodule

`default_nettype wire

// File: rtl/prm_checker.sv
// ----------------------------------------------------------------------------
// prm_checker: port-level checks of the peak region merger
// Watches the stream ports over time; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module prm_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tready,
    input wire logic [prm_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic                          m_tuser,
    input wire logic                          m_tlast,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready
);

    // a stalled result item holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
        && $stable(m_tuser) && $stable(m_tlast))
        else $error("stalled result item changed");

    // reset empties the output
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result item valid after reset");

    // every reported summit has treatment at least its control level
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ({m_tdata[105:90], 8'h00} >= m_tdata[129:106]))
        else $error("reported summit below control level");

    // input held off only while a reported peak is on its way out
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |=> m_tvalid)
        else $error("input stalled with no result item pending");

endmodule

bind peak_region_merger prm_checker u_prm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

`default_nettype wire
